// ----- rtl/rde_pkg.sv -----
// Shared types and constants for the reversible deque engine.
// No dependencies. Used by the interfaces, the controller, the datapath and the top level.
package rde_pkg;

    // Payload field widths
    localparam int ACTION_W  = 3;
    localparam int VALUE_W   = 16;
    localparam int ELEMENT_W = 16;
    localparam int STATUS_W  = 2;

    // Default sizing
    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 16;

    // Request action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 3'd0,
        ACT_PUSH    = 3'd1,
        ACT_REVERSE = 3'd2,
        ACT_DROP    = 3'd3,
        ACT_EMIT    = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ELEM  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERROR = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_PUSH,
        DP_REVERSE,
        DP_DROP,
        DP_EMIT_START,
        DP_EMIT_STEP,
        DP_STATUS_OUT
    } t_dp_op;

    // Controller -> datapath
    typedef struct packed {
        t_dp_op               op;
        t_status              code;
        logic [VALUE_W-1:0]   value;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic error;
        logic overflow;
        logic empty;
        logic slot_free;
        logic last_elem;
    } t_dp_sts;

endpackage

// ----- rtl/rde_if.sv -----
// Valid/ready channel interfaces for request and result traffic.
// Depends on rde_pkg for field widths.
interface rde_in_if;
    logic                          valid;
    logic                          ready;
    logic [rde_pkg::ACTION_W-1:0]  action;
    logic [rde_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface rde_out_if;
    logic                          valid;
    logic                          ready;
    logic [rde_pkg::ELEMENT_W-1:0] element;
    logic [rde_pkg::STATUS_W-1:0]  status;
    logic                          last;

    modport source (output valid, output element, output status, output last, input ready);
    modport sink   (input valid, input element, input status, input last, output ready);
endinterface

// ----- rtl/rde_ctrl.sv -----
// Controller FSM: takes requests, sequences emit runs and status results.
// Depends on rde_pkg and rde_in_if; drives the datapath through t_dp_cmd.
module rde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rde_in_if.sink            i_req,
    input  rde_pkg::t_dp_sts  i_sts,
    output rde_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_STATUS
    } t_state;

    t_state            r_state, n_state;
    rde_pkg::t_status  r_code,  n_code;
    logic              w_acc;

    // Requests are taken only between emit runs
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;

    // Command decode and next state
    always_comb begin
        o_cmd.op    = rde_pkg::DP_NOP;
        o_cmd.code  = r_code;
        o_cmd.value = i_req.value;
        n_state     = r_state;
        n_code      = r_code;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (rde_pkg::t_action'(i_req.action))
                        rde_pkg::ACT_CLEAR:   o_cmd.op = rde_pkg::DP_CLEAR;
                        rde_pkg::ACT_PUSH:    o_cmd.op = rde_pkg::DP_PUSH;
                        rde_pkg::ACT_REVERSE: o_cmd.op = rde_pkg::DP_REVERSE;
                        rde_pkg::ACT_DROP:    o_cmd.op = rde_pkg::DP_DROP;
                        rde_pkg::ACT_EMIT: begin
                            if (i_sts.error || i_sts.overflow || i_sts.empty) begin
                                // single status result, error wins over overflow
                                n_state = S_STATUS;
                                n_code  = i_sts.error    ? rde_pkg::ST_ERROR :
                                          i_sts.overflow ? rde_pkg::ST_OVER  :
                                                           rde_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.op = rde_pkg::DP_EMIT_START;
                                n_state  = S_EMIT;
                            end
                        end
                        default: o_cmd.op = rde_pkg::DP_NOP;
                    endcase
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.op = rde_pkg::DP_EMIT_STEP;
                    if (i_sts.last_elem) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_STATUS: begin
                if (i_sts.slot_free) begin
                    o_cmd.op = rde_pkg::DP_STATUS_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered status code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= rde_pkg::ST_EMPTY;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

// ----- rtl/rde_datapath.sv -----
// Datapath: ring store, head/count pointers, direction and sticky flags,
// emit read pointer and the result register. Depends on rde_pkg and rde_out_if.
module rde_datapath #(
    parameter int DEPTH      = rde_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rde_pkg::t_dp_cmd  i_cmd,
    output rde_pkg::t_dp_sts  o_sts,
    rde_out_if.source         o_res
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = PTR_W + 1;
    localparam int ELEM_W  = rde_pkg::ELEMENT_W;
    // pushed values are masked to VALUE_BITS, results carry ELEMENT_W bits
    localparam int STORE_W = (VALUE_BITS < rde_pkg::ELEMENT_W) ? VALUE_BITS
                                                              : rde_pkg::ELEMENT_W;

    logic [STORE_W-1:0]  r_mem [DEPTH];
    logic [STORE_W-1:0]  r_rdata;

    logic [PTR_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic                r_rev;
    logic                r_err;
    logic                r_ovf;
    logic [PTR_W-1:0]    r_rptr;
    logic [CNT_W-1:0]    r_rem;

    logic                r_out_vld;
    logic                r_out_is_elem;
    rde_pkg::t_status    r_out_status;
    logic                r_out_last;

    logic [SUM_W-1:0]    w_tail_sum;
    logic [SUM_W-1:0]    w_back_sum;
    logic [PTR_W-1:0]    w_tail;
    logic [PTR_W-1:0]    w_back;
    logic [PTR_W-1:0]    w_head_inc;
    logic [PTR_W-1:0]    w_rptr_inc;
    logic [PTR_W-1:0]    w_rptr_dec;
    logic                w_full;
    logic                w_slot_free;
    logic                w_load;

    // Ring arithmetic: sums stay below 2*DEPTH, one compare-subtract wraps them
    assign w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_back_sum = w_tail_sum - SUM_W'(1);
    assign w_tail     = (w_tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(w_tail_sum - SUM_W'(DEPTH))
                                                      : PTR_W'(w_tail_sum);
    assign w_back     = (w_back_sum >= SUM_W'(DEPTH)) ? PTR_W'(w_back_sum - SUM_W'(DEPTH))
                                                      : PTR_W'(w_back_sum);
    assign w_head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_rptr_inc = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
    assign w_rptr_dec = (r_rptr == '0) ? PTR_W'(DEPTH - 1) : r_rptr - PTR_W'(1);
    assign w_full     = (r_count == CNT_W'(DEPTH));

    // Result register is free when empty or being taken this cycle
    assign w_slot_free = !r_out_vld || o_res.ready;
    assign w_load      = (i_cmd.op == rde_pkg::DP_EMIT_STEP) ||
                         (i_cmd.op == rde_pkg::DP_STATUS_OUT);

    assign o_sts.error     = r_err;
    assign o_sts.overflow  = r_ovf;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.slot_free = w_slot_free;
    assign o_sts.last_elem = (r_rem == CNT_W'(1));

    // Pointer, flag and result register updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_rev         <= 1'b0;
            r_err         <= 1'b0;
            r_ovf         <= 1'b0;
            r_rptr        <= '0;
            r_rem         <= '0;
            r_out_vld     <= 1'b0;
            r_out_is_elem <= 1'b0;
            r_out_status  <= rde_pkg::ST_ELEM;
            r_out_last    <= 1'b0;
        end else begin
            // load wins; otherwise the result drops once taken
            r_out_vld <= w_load || (r_out_vld && !o_res.ready);
            case (i_cmd.op)
                rde_pkg::DP_CLEAR: begin
                    r_head  <= '0;
                    r_count <= '0;
                    r_rev   <= 1'b0;
                    r_err   <= 1'b0;
                    r_ovf   <= 1'b0;
                end
                rde_pkg::DP_PUSH: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                rde_pkg::DP_REVERSE: r_rev <= ~r_rev;
                rde_pkg::DP_DROP: begin
                    // ignored once the error flag is up
                    if (!r_err) begin
                        if (r_count == '0) begin
                            r_err <= 1'b1;
                        end else begin
                            if (!r_rev) begin
                                r_head <= w_head_inc;
                            end
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                end
                rde_pkg::DP_EMIT_START: begin
                    r_rptr <= r_rev ? w_back : r_head;
                    r_rem  <= r_count;
                end
                rde_pkg::DP_EMIT_STEP: begin
                    r_out_is_elem <= 1'b1;
                    r_out_status  <= rde_pkg::ST_ELEM;
                    r_out_last    <= (r_rem == CNT_W'(1));
                    r_rptr        <= r_rev ? w_rptr_dec : w_rptr_inc;
                    r_rem         <= r_rem - CNT_W'(1);
                end
                rde_pkg::DP_STATUS_OUT: begin
                    r_out_is_elem <= 1'b0;
                    r_out_status  <= i_cmd.code;
                    r_out_last    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Store: one write port for push, one registered read port for emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rde_pkg::DP_PUSH && !w_full) begin
            r_mem[w_tail] <= i_cmd.value[STORE_W-1:0];
        end
        if (i_cmd.op == rde_pkg::DP_EMIT_STEP) begin
            r_rdata <= r_mem[r_rptr];
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.element = r_out_is_elem ? ELEM_W'(r_rdata) : '0;
    assign o_res.status  = r_out_status;
    assign o_res.last    = r_out_last;

endmodule

// ----- rtl/reversible_deque_engine.sv -----
// Reversible deque engine: a ring store of DEPTH values with a lazy direction
// flag. After a clear, push, reverse, drop or unused action the next request
// is taken in the following cycle. An emit first loads the read pointer and
// count, then streams one element per cycle, while the result register is
// free, from the store's single registered read port; the next request is
// taken once the last element or a status result (empty, error, overflow) is
// loaded. The store is not cleared at reset; only entries pushed since the
// last clear are ever read. Depends on rde_pkg, rde_if, rde_ctrl and
// rde_datapath.
module reversible_deque_engine #(
    parameter int DEPTH      = rde_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rde_in_if.sink     i_cmd,
    rde_out_if.source  o_res
);

    rde_pkg::t_dp_cmd  w_cmd;
    rde_pkg::t_dp_sts  w_sts;

    // Sequencing
    rde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_cmd),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Store, pointers and result register
    rde_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_res)
    );

    // Results are only loaded into a free result register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == rde_pkg::DP_EMIT_STEP || w_cmd.op == rde_pkg::DP_STATUS_OUT)
        |-> w_sts.slot_free)
        else $error("result loaded while result register busy");

    // An emit run starts only on an accepted request
    a_start_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == rde_pkg::DP_EMIT_START) |-> (i_cmd.valid && i_cmd.ready))
        else $error("emit started without a request");

    // Status results carry a zero element and close the run
    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != rde_pkg::ST_ELEM)
        |-> (o_res.last && o_res.element == '0))
        else $error("malformed status result");

    // No result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule
